### rtl/core/rdq_pkg.sv
// Shared definitions for the ring deque: sizes, request codes and status codes.
// Used by ring_deque_push_both_pop_front_top; depends on nothing.
`timescale 1ns / 1ps

package rdq_pkg;

    localparam int DEPTH       = 16;
    localparam int ENTRY_WIDTH = 32;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef logic [PTR_W-1:0]       ptr_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [ENTRY_WIDTH-1:0] word_t;

    typedef enum logic [1:0] {
        MODE_PUSH_REAR  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

### rtl/core/ring_deque_push_both_pop_front_top.sv
// Ring deque top level: request decode, head/tail pointers, occupancy and result register.
// Depends on rdq_pkg and rdq_ram.
`timescale 1ns / 1ps
//
// Circular deque of 32-bit words. Each request word on the req channel
// (mode, entry_value) is push at rear, push at front or pop from front, and
// gives exactly one result word on the rsp channel (status, popped_value,
// entries_held). A word moves when valid is high and stall is low.
// The user must write capacity_in_use through cfg_write_en / cfg_write_data
// only while the block is idle; the block itself does not enforce this. 0 acts
// as 1 and values above 16 act as 16. A push or refused request shows its
// result in the cycle after it is taken; a successful pop shows it once
// rd_pend_reg and then rsp_valid_reg are set, the front word coming from the
// word RAM's registered read port. Pushes are taken one per cycle; a result
// waiting under rsp_stall is held and no request is taken then, nor while a
// pop's read is pending. Reset empties the deque, returns both pointers to
// slot 0 and sets the capacity to 16; the RAM contents are not cleared.

module ring_deque_push_both_pop_front_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [4:0]                cfg_write_data,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [1:0]                mode,
    input  logic [31:0]               entry_value,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [1:0]                status,
    output logic [31:0]               popped_value,
    output logic [4:0]                entries_held
);

    logic [4:0]     cap_cfg_reg;
    rdq_pkg::ptr_t  head_reg, head_next;
    rdq_pkg::ptr_t  tail_reg, tail_next;
    rdq_pkg::cnt_t  count_reg, count_next;
    logic           rd_pend_reg;
    logic           rsp_valid_reg, rsp_valid_next;
    logic           pop_ok_reg;
    rdq_pkg::status_t status_reg, status_next;
    rdq_pkg::cnt_t  held_reg;

    rdq_pkg::cnt_t  cap_eff;
    logic           accept;
    logic           take;
    logic           wr_en;
    rdq_pkg::ptr_t  wr_addr;
    logic           rd_en;
    rdq_pkg::word_t rd_data;
    rdq_pkg::cnt_t  tail_inc;
    rdq_pkg::cnt_t  head_inc;
    rdq_pkg::ptr_t  tail_step;
    rdq_pkg::ptr_t  head_step;
    rdq_pkg::ptr_t  head_back;

    assign req_stall = rd_pend_reg || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign take      = rsp_valid_reg && !rsp_stall;

    always_comb
    begin
        if (cap_cfg_reg == '0)
        begin
            cap_eff = rdq_pkg::CNT_W'(1);
        end
        else if (cap_cfg_reg > rdq_pkg::CNT_W'(rdq_pkg::DEPTH))
        begin
            cap_eff = rdq_pkg::CNT_W'(rdq_pkg::DEPTH);
        end
        else
        begin
            cap_eff = cap_cfg_reg;
        end
    end

    assign tail_inc  = rdq_pkg::CNT_W'(tail_reg) + rdq_pkg::CNT_W'(1);
    assign head_inc  = rdq_pkg::CNT_W'(head_reg) + rdq_pkg::CNT_W'(1);
    assign tail_step = (tail_inc >= cap_eff) ? '0 : tail_inc[rdq_pkg::PTR_W-1:0];
    assign head_step = (head_inc >= cap_eff) ? '0 : head_inc[rdq_pkg::PTR_W-1:0];
    assign head_back = (head_reg == '0)
                     ? rdq_pkg::PTR_W'(cap_eff - rdq_pkg::CNT_W'(1))
                     : head_reg - rdq_pkg::PTR_W'(1);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = rdq_pkg::ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_en       = 1'b0;
        unique case (mode)
            rdq_pkg::MODE_PUSH_REAR, rdq_pkg::MODE_PUSH_FRONT:
            begin
                if (count_reg >= cap_eff)
                begin
                    status_next = rdq_pkg::ST_FULL;
                end
                else if (count_reg == '0)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = rdq_pkg::CNT_W'(1);
                    wr_en      = accept;
                end
                else if (mode == rdq_pkg::MODE_PUSH_REAR)
                begin
                    tail_next  = tail_step;
                    wr_addr    = tail_step;
                    count_next = count_reg + rdq_pkg::CNT_W'(1);
                    wr_en      = accept;
                end
                else
                begin
                    head_next  = head_back;
                    wr_addr    = head_back;
                    count_next = count_reg + rdq_pkg::CNT_W'(1);
                    wr_en      = accept;
                end
            end
            rdq_pkg::MODE_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    status_next = rdq_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en      = accept;
                    count_next = count_reg - rdq_pkg::CNT_W'(1);
                    if (count_reg == rdq_pkg::CNT_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        head_next = head_step;
                    end
                end
            end
            default:
            begin
                status_next = rdq_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        priority if (rd_pend_reg)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (accept)
        begin
            rsp_valid_next = !rd_en;
        end
        else if (take)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg   <= 5'd16;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_cfg_reg <= cfg_write_data;
            end
            if (accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            rd_pend_reg   <= accept && rd_en;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            held_reg   <= count_next;
            pop_ok_reg <= rd_en;
        end
    end

    rdq_ram #(
        .WIDTH (rdq_pkg::ENTRY_WIDTH),
        .DEPTH (rdq_pkg::DEPTH)
    ) u_word_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (entry_value),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign entries_held = held_reg;
    assign popped_value = pop_ok_reg ? rd_data : '0;

endmodule

### rtl/core/rdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the deque words for the top level.
`timescale 1ns / 1ps

module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
